>>> hdl/asl_pkg.sv
// Shared types and constants for the assembler source lexer.
package asl_pkg;

    // Width of every position field on the result port
    localparam int FIELD_W = 20;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Lexer modes
    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_COMMENT   = 4'd1,
        M_PSLASH    = 4'd2,
        M_PBANG     = 4'd3,
        M_PDOLLAR   = 4'd4,
        M_PPERCENT  = 4'd5,
        M_DIRECTIVE = 4'd6,
        M_DEC       = 4'd7,
        M_HEX       = 4'd8,
        M_BIN       = 4'd9,
        M_IDENT     = 4'd10,
        M_STRING    = 4'd11,
        M_ESC       = 4'd12
    } lex_mode_t;

    // Token kinds
    typedef enum logic [3:0] {
        K_NEWLINE   = 4'd0,
        K_COMMENT   = 4'd1,
        K_DIRECTIVE = 4'd2,
        K_NUMBER    = 4'd3,
        K_IDENT     = 4'd4,
        K_STRING    = 4'd5,
        K_HASH      = 4'd6,
        K_DOLLAR    = 4'd7,
        K_PERCENT   = 4'd8,
        K_COMMA     = 4'd9,
        K_COLON     = 4'd10,
        K_LPAREN    = 4'd11,
        K_RPAREN    = 4'd12,
        K_LBRACE    = 4'd13,
        K_RBRACE    = 4'd14,
        K_EOF       = 4'd15
    } token_kind_t;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Special characters
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // One result item
    typedef struct packed {
        token_kind_t          kind;
        logic [FIELD_W-1:0]   start_offset;
        logic [FIELD_W-1:0]   text_length;
        logic [FIELD_W-1:0]   line_number;
        logic [FIELD_W-1:0]   column_number;
        logic                 last_of_run;
    } token_t;

endpackage

>>> hdl/asl_step.sv
// Next-state and token logic for one source byte or end item.
module asl_step #(
    parameter int POSITION_BITS = 20
) (
    input  logic                      action,
    input  logic [7:0]                ch,
    input  asl_pkg::lex_mode_t        mode,
    input  logic [POSITION_BITS-1:0]  open_offset,
    input  logic [POSITION_BITS-1:0]  open_line,
    input  logic [POSITION_BITS-1:0]  open_column,
    input  logic [POSITION_BITS-1:0]  byte_pos,
    input  logic [POSITION_BITS-1:0]  line_cnt,
    input  logic [POSITION_BITS-1:0]  col_cnt,
    output asl_pkg::lex_mode_t        mode_next,
    output logic [POSITION_BITS-1:0]  open_offset_next,
    output logic [POSITION_BITS-1:0]  open_line_next,
    output logic [POSITION_BITS-1:0]  open_column_next,
    output logic [POSITION_BITS-1:0]  byte_pos_next,
    output logic [POSITION_BITS-1:0]  line_cnt_next,
    output logic [POSITION_BITS-1:0]  col_cnt_next,
    output logic [1:0]                push_n,
    output asl_pkg::token_t           tok0,
    output asl_pkg::token_t           tok1
);
    import asl_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
        return (x == {POSITION_BITS{1'b1}}) ? x : x + POS_ONE;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_bin(input logic [7:0] c);
        return c == "0" || c == "1";
    endfunction

    // Byte handled fresh (idle mode) and the column it sees
    logic                     pre_inc;
    logic [POSITION_BITS-1:0] col_pre;
    lex_mode_t                idle_mode;
    logic                     idle_open;
    logic                     idle_emit;
    token_kind_t              idle_kind;
    logic [POSITION_BITS-1:0] idle_line;
    logic [POSITION_BITS-1:0] idle_col;

    // Open-token emission and second emission
    logic                     relex;
    logic                     a_valid;
    token_kind_t              a_kind;
    logic [POSITION_BITS-1:0] a_end;
    logic [POSITION_BITS-1:0] a_len;
    logic                     b_valid;
    token_kind_t              b_kind;
    logic [POSITION_BITS-1:0] b_len;
    logic [POSITION_BITS-1:0] b_col;
    token_t                   tok_a;
    token_t                   tok_b;

    // A dropped slash still counts one column before the byte is relexed
    assign pre_inc = (action == ACT_BYTE) && (mode == M_PSLASH) && (ch != CH_SLASH);
    assign col_pre = pre_inc ? sat_inc(col_cnt) : col_cnt;

    // Classification of a fresh byte
    always_comb
    begin
        idle_mode = M_IDLE;
        idle_open = 1'b0;
        idle_emit = 1'b0;
        idle_kind = K_NEWLINE;
        idle_line = line_cnt;
        idle_col  = sat_inc(col_pre);
        if (ch == CH_LF)
        begin
            idle_emit = 1'b1;
            idle_line = sat_inc(line_cnt);
            idle_col  = POS_ONE;
        end
        else if (ch == CH_SEMI)
        begin
            idle_mode = M_COMMENT;
            idle_open = 1'b1;
            idle_col  = col_pre;
        end
        else if (ch == CH_SLASH)
        begin
            idle_mode = M_PSLASH;
            idle_open = 1'b1;
            idle_col  = col_pre;
        end
        else if (ch == CH_BANG)
        begin
            idle_mode = M_PBANG;
            idle_open = 1'b1;
        end
        else if (is_digit(ch))
        begin
            idle_mode = M_DEC;
            idle_open = 1'b1;
        end
        else if (ch == CH_DOLLAR)
        begin
            idle_mode = M_PDOLLAR;
            idle_open = 1'b1;
        end
        else if (ch == CH_PERCENT)
        begin
            idle_mode = M_PPERCENT;
            idle_open = 1'b1;
        end
        else if (is_alpha(ch) || ch == CH_UNDER)
        begin
            idle_mode = M_IDENT;
            idle_open = 1'b1;
        end
        else if (ch == CH_QUOTE)
        begin
            idle_mode = M_STRING;
            idle_open = 1'b1;
        end
        else
        begin
            idle_emit = 1'b1;
            unique case (ch)
                CH_HASH:   idle_kind = K_HASH;
                CH_COMMA:  idle_kind = K_COMMA;
                CH_COLON:  idle_kind = K_COLON;
                CH_LPAREN: idle_kind = K_LPAREN;
                CH_RPAREN: idle_kind = K_RPAREN;
                CH_LBRACE: idle_kind = K_LBRACE;
                CH_RBRACE: idle_kind = K_RBRACE;
                default:   idle_emit = 1'b0;
            endcase
        end
    end

    // Mode step: state update and which tokens come out
    always_comb
    begin
        mode_next        = mode;
        open_offset_next = open_offset;
        open_line_next   = open_line;
        open_column_next = open_column;
        byte_pos_next    = sat_inc(byte_pos);
        line_cnt_next    = line_cnt;
        col_cnt_next     = col_cnt;
        relex            = 1'b0;
        a_valid          = 1'b0;
        a_kind           = K_NEWLINE;
        a_end            = byte_pos;
        b_valid          = 1'b0;
        b_kind           = K_EOF;
        b_len            = '0;
        b_col            = col_cnt;

        if (action == ACT_END)
        begin
            // flush the open token, then end of file
            unique case (mode)
                M_COMMENT:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_COMMENT;
                end
                M_PSLASH:
                    b_col = sat_inc(col_cnt);
                M_PDOLLAR:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_DOLLAR;
                    a_end   = sat_inc(open_offset);
                end
                M_PPERCENT:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_PERCENT;
                    a_end   = sat_inc(open_offset);
                end
                M_DIRECTIVE:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_DIRECTIVE;
                end
                M_DEC, M_HEX, M_BIN:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_NUMBER;
                end
                M_IDENT:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_IDENT;
                end
                M_STRING, M_ESC:
                begin
                    a_valid = 1'b1;
                    a_kind  = K_STRING;
                end
                default:
                    a_valid = 1'b0;
            endcase
            b_valid          = 1'b1;
            mode_next        = M_IDLE;
            open_offset_next = '0;
            open_line_next   = POS_ONE;
            open_column_next = POS_ONE;
            byte_pos_next    = '0;
            line_cnt_next    = POS_ONE;
            col_cnt_next     = POS_ONE;
        end
        else
        begin
            unique case (mode)
                M_COMMENT:
                begin
                    if (ch == CH_LF)
                    begin
                        a_valid = 1'b1;
                        a_kind  = K_COMMENT;
                        relex   = 1'b1;
                    end
                end
                M_PSLASH:
                begin
                    if (ch == CH_SLASH)
                        mode_next = M_COMMENT;
                    else
                        relex = 1'b1;
                end
                M_PBANG:
                begin
                    if (is_alpha(ch))
                    begin
                        open_offset_next = byte_pos;
                        mode_next        = M_DIRECTIVE;
                        col_cnt_next     = sat_inc(col_cnt);
                    end
                    else
                        relex = 1'b1;
                end
                M_PDOLLAR:
                begin
                    if (is_xdigit(ch))
                    begin
                        mode_next    = M_HEX;
                        col_cnt_next = sat_inc(col_cnt);
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = K_DOLLAR;
                        a_end   = sat_inc(open_offset);
                        relex   = 1'b1;
                    end
                end
                M_PPERCENT:
                begin
                    if (is_bin(ch))
                    begin
                        mode_next    = M_BIN;
                        col_cnt_next = sat_inc(col_cnt);
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = K_PERCENT;
                        a_end   = sat_inc(open_offset);
                        relex   = 1'b1;
                    end
                end
                M_DIRECTIVE, M_DEC, M_HEX, M_BIN, M_IDENT:
                begin
                    // run tokens: keep the byte or close and relex it
                    if ((mode == M_DIRECTIVE && (is_alpha(ch) || is_digit(ch)
                                                 || ch == CH_UNDER))
                        || (mode == M_DEC && is_digit(ch))
                        || (mode == M_HEX && is_xdigit(ch))
                        || (mode == M_BIN && is_bin(ch))
                        || (mode == M_IDENT && (is_alpha(ch) || is_digit(ch)
                                                || ch == CH_UNDER || ch == CH_DOT)))
                        col_cnt_next = sat_inc(col_cnt);
                    else
                    begin
                        a_valid = 1'b1;
                        relex   = 1'b1;
                        if (mode == M_DIRECTIVE)
                            a_kind = K_DIRECTIVE;
                        else if (mode == M_IDENT)
                            a_kind = K_IDENT;
                        else
                            a_kind = K_NUMBER;
                    end
                end
                M_STRING:
                begin
                    col_cnt_next = sat_inc(col_cnt);
                    if (ch == CH_BSLASH)
                        mode_next = M_ESC;
                    else if (ch == CH_QUOTE)
                    begin
                        a_valid   = 1'b1;
                        a_kind    = K_STRING;
                        a_end     = sat_inc(byte_pos);
                        mode_next = M_IDLE;
                    end
                end
                M_ESC:
                begin
                    col_cnt_next = sat_inc(col_cnt);
                    mode_next    = M_STRING;
                end
                default:
                    relex = 1'b1;
            endcase

            if (relex)
            begin
                mode_next     = idle_mode;
                line_cnt_next = idle_line;
                col_cnt_next  = idle_col;
                b_valid       = idle_emit;
                b_kind        = idle_kind;
                b_len         = POS_ONE;
                b_col         = col_pre;
                if (idle_open)
                begin
                    open_offset_next = byte_pos;
                    open_line_next   = line_cnt;
                    open_column_next = col_pre;
                end
            end
        end
    end

    // Length of the open token, clamped at zero
    assign a_len = (a_end >= open_offset) ? a_end - open_offset : '0;

    // Result formatting
    always_comb
    begin
        tok_a.kind          = a_kind;
        tok_a.start_offset  = FIELD_W'(open_offset);
        tok_a.text_length   = FIELD_W'(a_len);
        tok_a.line_number   = FIELD_W'(open_line);
        tok_a.column_number = FIELD_W'(open_column);
        tok_a.last_of_run   = ~b_valid;

        tok_b.kind          = b_kind;
        tok_b.start_offset  = FIELD_W'(byte_pos);
        tok_b.text_length   = FIELD_W'(b_len);
        tok_b.line_number   = FIELD_W'(line_cnt);
        tok_b.column_number = FIELD_W'(b_col);
        tok_b.last_of_run   = 1'b1;

        tok0   = a_valid ? tok_a : tok_b;
        tok1   = tok_b;
        push_n = {1'b0, a_valid} + {1'b0, b_valid};
    end

endmodule

>>> hdl/asl_queue.sv
// Four-entry result queue: up to two writes and one read per cycle.
module asl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  asl_pkg::token_t   tok0,
    input  asl_pkg::token_t   tok1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output asl_pkg::token_t   out_tok
);
    import asl_pkg::*;

    token_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 pop;

    // Status
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign pop       = out_valid && !out_stall;
    assign out_tok   = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= tok0;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_reg + 1'b1] <= tok1;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> count_reg <= Q_CNT_W'(Q_DEPTH - 2))
        else $error("push without two free entries");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == Q_PTR_W'(count_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

>>> hdl/assembler_source_lexer.sv
// Top level of the assembler source lexer: state registers, step logic, result queue.
// Tokens are written into the result queue registers before the result port offers them.
// Throughput: one item per cycle; an item that closes a token and emits another takes
// two result transfers, and the result port drains at most one token per cycle.
// Input stalls only while fewer than two queue entries are free.
// Reset clears the lexer mode, counters and queue at once; no clearing pass.
module assembler_source_lexer #(
    parameter int POSITION_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [7:0]                     ch,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [3:0]                     token_kind,
    output logic [asl_pkg::FIELD_W-1:0]    start_offset,
    output logic [asl_pkg::FIELD_W-1:0]    text_length,
    output logic [asl_pkg::FIELD_W-1:0]    line_number,
    output logic [asl_pkg::FIELD_W-1:0]    column_number,
    output logic                           last_of_run
);
    import asl_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    lex_mode_t                mode_reg;
    lex_mode_t                mode_next;
    logic [POSITION_BITS-1:0] open_offset_reg;
    logic [POSITION_BITS-1:0] open_offset_next;
    logic [POSITION_BITS-1:0] open_line_reg;
    logic [POSITION_BITS-1:0] open_line_next;
    logic [POSITION_BITS-1:0] open_column_reg;
    logic [POSITION_BITS-1:0] open_column_next;
    logic [POSITION_BITS-1:0] byte_pos_reg;
    logic [POSITION_BITS-1:0] byte_pos_next;
    logic [POSITION_BITS-1:0] line_reg;
    logic [POSITION_BITS-1:0] line_next;
    logic [POSITION_BITS-1:0] col_reg;
    logic [POSITION_BITS-1:0] col_next;

    logic [1:0]  step_push_n;
    logic [1:0]  push_n;
    token_t      tok0;
    token_t      tok1;
    token_t      out_tok;
    logic        room;
    logic        in_xfer;

    assign in_stall = ~room;
    assign in_xfer  = in_valid && room;
    assign push_n   = in_xfer ? step_push_n : 2'd0;

    // Per-item lexer step
    asl_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .action           (action),
        .ch               (ch),
        .mode             (mode_reg),
        .open_offset      (open_offset_reg),
        .open_line        (open_line_reg),
        .open_column      (open_column_reg),
        .byte_pos         (byte_pos_reg),
        .line_cnt         (line_reg),
        .col_cnt          (col_reg),
        .mode_next        (mode_next),
        .open_offset_next (open_offset_next),
        .open_line_next   (open_line_next),
        .open_column_next (open_column_next),
        .byte_pos_next    (byte_pos_next),
        .line_cnt_next    (line_next),
        .col_cnt_next     (col_next),
        .push_n           (step_push_n),
        .tok0             (tok0),
        .tok1             (tok1)
    );

    // Lexer state, advanced on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_IDLE;
            open_offset_reg <= '0;
            open_line_reg   <= POS_ONE;
            open_column_reg <= POS_ONE;
            byte_pos_reg    <= '0;
            line_reg        <= POS_ONE;
            col_reg         <= POS_ONE;
        end
        else if (in_xfer)
        begin
            mode_reg        <= mode_next;
            open_offset_reg <= open_offset_next;
            open_line_reg   <= open_line_next;
            open_column_reg <= open_column_next;
            byte_pos_reg    <= byte_pos_next;
            line_reg        <= line_next;
            col_reg         <= col_next;
        end
    end

    // Result queue
    asl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .tok0      (tok0),
        .tok1      (tok1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tok   (out_tok)
    );

    assign token_kind    = out_tok.kind;
    assign start_offset  = out_tok.start_offset;
    assign text_length   = out_tok.text_length;
    assign line_number   = out_tok.line_number;
    assign column_number = out_tok.column_number;
    assign last_of_run   = out_tok.last_of_run;

`ifndef SYNTHESIS
    a_counters_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0 && col_reg != '0)
        else $error("line or column counter reached zero");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && action == ACT_END |=> mode_reg == M_IDLE && byte_pos_reg == '0
                                         && line_reg == POS_ONE && col_reg == POS_ONE)
        else $error("end item did not restart the lexer");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && action == ACT_BYTE && byte_pos_reg != {POSITION_BITS{1'b1}}
        |=> byte_pos_reg == POSITION_BITS'($past(byte_pos_reg) + POS_ONE))
        else $error("byte position did not advance");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && action == ACT_END |-> step_push_n != 2'd0)
        else $error("end item produced no end-of-file token");
`endif

endmodule

>>> tb/lexer_token_checker.sv
// Token checker for the assembler source lexer: predicts tokens from input transfers and compares.
module lexer_token_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    ch,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [3:0]                    token_kind,
    input  logic [asl_pkg::FIELD_W-1:0]   start_offset,
    input  logic [asl_pkg::FIELD_W-1:0]   text_length,
    input  logic [asl_pkg::FIELD_W-1:0]   line_number,
    input  logic [asl_pkg::FIELD_W-1:0]   column_number,
    input  logic                          last_of_run,
    output int                            fail_count,
    output int                            tokens_left
);
    import asl_pkg::*;

    typedef logic [FIELD_W-1:0] pos_t;

    // Predicted lexer state
    lex_mode_t mode;
    pos_t      tok_off;
    pos_t      tok_line;
    pos_t      tok_col;
    pos_t      byte_pos;
    pos_t      line_cnt;
    pos_t      col_cnt;

    // Tokens of the current input transfer, then all tokens still awaited
    token_t    step_out [0:1];
    int        step_count;
    token_t    expected_tokens [$];

    // Counters stop at all ones
    function automatic pos_t bump(input pos_t x);
        return (x == {FIELD_W{1'b1}}) ? x : x + 1'b1;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_bin(input logic [7:0] c);
        return c == "0" || c == "1";
    endfunction

    task automatic clear_lexer();
        mode     = M_IDLE;
        tok_off  = '0;
        tok_line = pos_t'(1);
        tok_col  = pos_t'(1);
        byte_pos = '0;
        line_cnt = pos_t'(1);
        col_cnt  = pos_t'(1);
    endtask

    task automatic push_token(input token_kind_t k, input pos_t off, input pos_t len,
                              input pos_t ln, input pos_t cl);
        token_t t;
        t.kind          = k;
        t.start_offset  = off;
        t.text_length   = len;
        t.line_number   = ln;
        t.column_number = cl;
        t.last_of_run   = 1'b0;
        if (step_count < 2)
            step_out[step_count] = t;
        step_count++;
    endtask

    // Close the open token with its text ending just before end_pos
    task automatic push_open(input token_kind_t k, input pos_t end_pos);
        push_token(k, tok_off, (end_pos >= tok_off) ? end_pos - tok_off : '0,
                   tok_line, tok_col);
    endtask

    task automatic open_at(input lex_mode_t m);
        tok_off  = byte_pos;
        tok_line = line_cnt;
        tok_col  = col_cnt;
        mode     = m;
    endtask

    // A byte seen with no token open
    task automatic fresh_byte(input logic [7:0] c);
        token_kind_t k;
        bit          single;
        k      = K_HASH;
        single = 1'b0;
        mode   = M_IDLE;
        if (c == CH_LF) begin
            push_token(K_NEWLINE, byte_pos, pos_t'(1), line_cnt, col_cnt);
            line_cnt = bump(line_cnt);
            col_cnt  = pos_t'(1);
        end
        else if (c == CH_SEMI) begin
            open_at(M_COMMENT);
        end
        else if (c == CH_SLASH) begin
            open_at(M_PSLASH);
        end
        else begin
            if (c == CH_BANG)
                open_at(M_PBANG);
            else if (is_dig(c))
                open_at(M_DEC);
            else if (c == CH_DOLLAR)
                open_at(M_PDOLLAR);
            else if (c == CH_PERCENT)
                open_at(M_PPERCENT);
            else if (is_letter(c) || c == CH_UNDER)
                open_at(M_IDENT);
            else if (c == CH_QUOTE)
                open_at(M_STRING);
            else begin
                single = 1'b1;
                case (c)
                    CH_HASH:   k = K_HASH;
                    CH_COMMA:  k = K_COMMA;
                    CH_COLON:  k = K_COLON;
                    CH_LPAREN: k = K_LPAREN;
                    CH_RPAREN: k = K_RPAREN;
                    CH_LBRACE: k = K_LBRACE;
                    CH_RBRACE: k = K_RBRACE;
                    default:   single = 1'b0;
                endcase
                if (single)
                    push_token(k, byte_pos, pos_t'(1), line_cnt, col_cnt);
            end
            col_cnt = bump(col_cnt);
        end
    endtask

    // Extend a run token, or close it and relex the byte
    task automatic run_or_close(input bit keep, input token_kind_t k, input logic [7:0] c);
        if (keep)
            col_cnt = bump(col_cnt);
        else begin
            push_open(k, byte_pos);
            fresh_byte(c);
        end
    endtask

    // One accepted input transfer
    task automatic lex_step(input logic act, input logic [7:0] c);
        int i;
        step_count = 0;
        if (act == ACT_END) begin
            case (mode)
                M_COMMENT:          push_open(K_COMMENT, byte_pos);
                M_PSLASH:           col_cnt = bump(col_cnt);
                M_PDOLLAR:          push_open(K_DOLLAR, bump(tok_off));
                M_PPERCENT:         push_open(K_PERCENT, bump(tok_off));
                M_DIRECTIVE:        push_open(K_DIRECTIVE, byte_pos);
                M_DEC, M_HEX, M_BIN: push_open(K_NUMBER, byte_pos);
                M_IDENT:            push_open(K_IDENT, byte_pos);
                M_STRING, M_ESC:    push_open(K_STRING, byte_pos);
                default:            ;
            endcase
            push_token(K_EOF, byte_pos, '0, line_cnt, col_cnt);
            clear_lexer();
        end
        else begin
            case (mode)
                M_COMMENT:
                    if (c == CH_LF) begin
                        push_open(K_COMMENT, byte_pos);
                        fresh_byte(c);
                    end
                M_PSLASH:
                    if (c == CH_SLASH)
                        mode = M_COMMENT;
                    else begin
                        col_cnt = bump(col_cnt);
                        fresh_byte(c);
                    end
                M_PBANG:
                    if (is_letter(c)) begin
                        tok_off = byte_pos;
                        mode    = M_DIRECTIVE;
                        col_cnt = bump(col_cnt);
                    end
                    else
                        fresh_byte(c);
                M_PDOLLAR:
                    if (is_hex(c)) begin
                        mode    = M_HEX;
                        col_cnt = bump(col_cnt);
                    end
                    else begin
                        push_open(K_DOLLAR, bump(tok_off));
                        fresh_byte(c);
                    end
                M_PPERCENT:
                    if (is_bin(c)) begin
                        mode    = M_BIN;
                        col_cnt = bump(col_cnt);
                    end
                    else begin
                        push_open(K_PERCENT, bump(tok_off));
                        fresh_byte(c);
                    end
                M_DIRECTIVE:
                    run_or_close(is_letter(c) || is_dig(c) || c == CH_UNDER, K_DIRECTIVE, c);
                M_DEC: run_or_close(is_dig(c), K_NUMBER, c);
                M_HEX: run_or_close(is_hex(c), K_NUMBER, c);
                M_BIN: run_or_close(is_bin(c), K_NUMBER, c);
                M_IDENT:
                    run_or_close(is_letter(c) || is_dig(c) || c == CH_UNDER || c == CH_DOT,
                                 K_IDENT, c);
                M_STRING: begin
                    col_cnt = bump(col_cnt);
                    if (c == CH_BSLASH)
                        mode = M_ESC;
                    else if (c == CH_QUOTE) begin
                        push_open(K_STRING, bump(byte_pos));
                        mode = M_IDLE;
                    end
                end
                M_ESC: begin
                    col_cnt = bump(col_cnt);
                    mode    = M_STRING;
                end
                default: fresh_byte(c);
            endcase
            byte_pos = bump(byte_pos);
        end
        if (step_count > 2) begin
            $display("%0t: predictor produced %0d tokens for one transfer", $time, step_count);
            fail_count++;
            step_count = 2;
        end
        if (step_count > 0)
            step_out[step_count - 1].last_of_run = 1'b1;
        for (i = 0; i < step_count; i++)
            expected_tokens = {expected_tokens, step_out[i]};
    endtask

    task automatic check_field(input string field, input pos_t want_v, input pos_t got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // Compare output transfers first, then predict from input transfers
    always @(posedge clk or negedge rst_n) begin
        token_t want;
        if (!rst_n) begin
            clear_lexer();
            expected_tokens.delete();
            step_count  = 0;
            fail_count  = 0;
            tokens_left = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected token: expected none, got kind %0d offset %0d",
                             $time, token_kind, start_offset);
                    fail_count++;
                end
                else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", pos_t'(want.kind), pos_t'(token_kind));
                    check_field("start_offset", want.start_offset, start_offset);
                    check_field("text_length", want.text_length, text_length);
                    check_field("line_number", want.line_number, line_number);
                    check_field("column_number", want.column_number, column_number);
                    check_field("last_of_run", pos_t'(want.last_of_run), pos_t'(last_of_run));
                end
            end
            if (in_valid && !in_stall)
                lex_step(action, ch);
            tokens_left = expected_tokens.size();
        end
    end

endmodule

>>> tb/assembler_source_lexer_tb.sv
// Testbench top for the assembler source lexer: clock, reset, source stimulus and verdict.
module assembler_source_lexer_tb;
    import asl_pkg::*;

    localparam int    CYCLE_LIMIT   = 100000;
    localparam int    RANDOM_ITEMS  = 400;
    localparam string ID_START      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string ID_BODY       =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
    localparam string LETTERS       = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DIGITS        = "0123456789";
    localparam string HEX_DIGITS    = "0123456789abcdefABCDEF";
    localparam string DIR_BODY      =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                action;
    logic [7:0]          ch;
    logic                out_valid;
    logic                out_stall;
    logic [3:0]          token_kind;
    logic [FIELD_W-1:0]  start_offset;
    logic [FIELD_W-1:0]  text_length;
    logic [FIELD_W-1:0]  line_number;
    logic [FIELD_W-1:0]  column_number;
    logic                last_of_run;

    int                  fail_count;
    int                  tokens_left;
    int                  items_sent;
    int                  cycle_count;
    bit                  drain_now;
    logic                calm;

    // Window where neither side idles
    assign calm = (items_sent >= 260) && (items_sent < 340);

    assembler_source_lexer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .ch            (ch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .text_length   (text_length),
        .line_number   (line_number),
        .column_number (column_number),
        .last_of_run   (last_of_run)
    );

    lexer_token_checker token_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .ch            (ch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .text_length   (text_length),
        .line_number   (line_number),
        .column_number (column_number),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .tokens_left   (tokens_left)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && items_sent >= 200) begin
                held      = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 21);
        end
    end

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // One input transfer, then an optional gap or a full drain
    task automatic send_item(input logic act, input logic [7:0] c);
        in_valid <= 1'b1;
        action   <= act;
        ch       <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (drain_now) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (tokens_left != 0)
                @(posedge clk);
            drain_now = 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 21) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 21);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(ACT_BYTE, s[i]);
    endtask

    // Random source fragment: mostly well-formed tokens, some noise and end items
    task automatic send_fragment();
        int          sel;
        int          n;
        int          i;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 16) begin
            send_item(ACT_BYTE, pick(ID_START));
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++)
                send_item(ACT_BYTE, pick(ID_BODY));
        end
        else if (sel < 26) begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                send_item(ACT_BYTE, pick(DIGITS));
        end
        else if (sel < 36) begin
            send_item(ACT_BYTE, CH_DOLLAR);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                send_item(ACT_BYTE, pick(HEX_DIGITS));
        end
        else if (sel < 44) begin
            send_item(ACT_BYTE, CH_PERCENT);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                send_item(ACT_BYTE, pick("01"));
        end
        else if (sel < 52) begin
            // directive, sometimes a bang that is not followed by a letter
            send_item(ACT_BYTE, CH_BANG);
            if ($urandom_range(0, 99) < 85)
                send_item(ACT_BYTE, pick(LETTERS));
            else
                send_item(ACT_BYTE, pick("1_ ;!"));
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                send_item(ACT_BYTE, pick(DIR_BODY));
        end
        else if (sel < 60) begin
            if ($urandom_range(0, 1) == 0)
                send_item(ACT_BYTE, CH_SEMI);
            else begin
                send_item(ACT_BYTE, CH_SLASH);
                send_item(ACT_BYTE, CH_SLASH);
            end
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) begin
                b = 8'($urandom_range(0, 255));
                send_item(ACT_BYTE, (b == CH_LF) ? 8'h20 : b);
            end
            if ($urandom_range(0, 99) < 70)
                send_item(ACT_BYTE, CH_LF);
        end
        else if (sel < 68) begin
            // string with escapes and embedded newlines
            send_item(ACT_BYTE, CH_QUOTE);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                b = 8'($urandom_range(0, 99));
                if (b < 15) begin
                    send_item(ACT_BYTE, CH_BSLASH);
                    send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                end
                else if (b < 25)
                    send_item(ACT_BYTE, CH_LF);
                else
                    send_item(ACT_BYTE, 8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 99) < 85)
                send_item(ACT_BYTE, CH_QUOTE);
        end
        else if (sel < 80)
            send_item(ACT_BYTE, pick("#,:(){}/!$%"));
        else if (sel < 92)
            send_item(ACT_BYTE, pick(" \t\n \n"));
        else if (sel < 97)
            send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        else
            send_item(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict
    initial begin
        int  random_start;
        bit  drained;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_BYTE;
        ch         = 8'h00;
        items_sent = 0;
        drain_now  = 1'b0;
        drained    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A directive, numbers of each base, lone dollar and percent, single
        // characters, a dropped bang, a dropped slash and an unknown high byte
        send_text("!z$f%1$,%#:(){}!1/x");
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_END, 8'h00);
        // Slash comment, newline inside a string, string ending in a lone backslash
        send_text("//;\n\"\n\\");
        send_item(ACT_END, 8'hFF);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (!drained && items_sent >= 120) begin
                drained   = 1'b1;
                drain_now = 1'b1;
            end
            send_fragment();
        end
        send_item(ACT_END, 8'($urandom_range(0, 255)));

        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_left != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
